### rtl/cfs_pkg.sv
// ----------------------------------------------------------------------------
// cfs_pkg
// Shared constants, codes and types of the circular FIFO with search.
// ----------------------------------------------------------------------------
package cfs_pkg;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 7;

    // Default number of slots
    localparam int DEPTH_DEF = 64;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SRCH = 2'd2;

    // Head and tail word reported for an empty queue
    localparam logic [WORD_W-1:0] EMPTY_WORD = 32'hFFFF_FFFF;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEAD,
        ST_SCAN
    } t_state;

    // Status from the scan unit to the sequencer
    typedef struct packed {
        logic done;
        logic found;
    } t_scan_sts;

endpackage

### rtl/circular_fifo_with_search.sv
// ----------------------------------------------------------------------------
// circular_fifo_with_search
// Ring-buffer FIFO of 32-bit words with enqueue, dequeue and search requests.
// ----------------------------------------------------------------------------
// Each accepted request gives one result, held in an output register until it
// is taken. An enqueue, a refused request, a dequeue that empties the queue
// and a search of an empty queue finish in the cycle they are accepted. A
// dequeue that leaves words behind passes through the head-fetch state, ST_HEAD:
// the new head word is fetched through the slot RAM's read port. A search of N
// live entries is run by the scan unit, reading one slot per cycle through
// that same port; it stops early at the first match. A new request is taken
// once the block is idle and the output register is free or being emptied.
// The slot RAM needs no clearing after reset.
module circular_fifo_with_search #(
    parameter int DEPTH = cfs_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [cfs_pkg::CMD_W-1:0]     i_cmd,
    input  logic signed [cfs_pkg::WORD_W-1:0] i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_ok,
    output logic signed [cfs_pkg::WORD_W-1:0] o_popped_value,
    output logic                          o_found,
    output logic signed [cfs_pkg::WORD_W-1:0] o_head_value,
    output logic signed [cfs_pkg::WORD_W-1:0] o_tail_value,
    output logic [cfs_pkg::COUNT_W-1:0]   o_count
);

    import cfs_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_state            r_state, n_state;
    logic [PTR_W-1:0]  r_rd_idx, n_rd_idx;
    logic [PTR_W-1:0]  r_wr_idx, n_wr_idx;
    logic [OCC_W-1:0]  r_occ,    n_occ;
    logic [WORD_W-1:0] r_head,   n_head;
    logic [WORD_W-1:0] r_tail,   n_tail;

    logic              r_out_valid;
    logic              r_ok;
    logic [WORD_W-1:0] r_pop;
    logic              r_found;
    logic [WORD_W-1:0] r_head_out;
    logic [WORD_W-1:0] r_tail_out;
    logic [OCC_W-1:0]  r_occ_out;

    logic              accept;
    logic              full;
    logic [PTR_W-1:0]  rd_idx_next;
    logic [PTR_W-1:0]  wr_idx_next;

    logic              ram_we;
    logic              ram_re;
    logic [PTR_W-1:0]  ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic              head_re;

    logic              scan_start;
    logic              scan_rd_en;
    logic [PTR_W-1:0]  scan_rd_addr;
    t_scan_sts         scan_sts;

    logic              res_load;
    logic              res_ok;
    logic [WORD_W-1:0] res_pop;
    logic              res_found;

    logic [OCC_W+COUNT_W-1:0] count_ext;

    // Handshake and pointer arithmetic
    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign full        = (r_occ == OCC_W'(DEPTH));
    assign rd_idx_next = (r_rd_idx == PTR_LAST) ? '0 : r_rd_idx + 1'b1;
    assign wr_idx_next = (r_wr_idx == PTR_LAST) ? '0 : r_wr_idx + 1'b1;

    // Share the RAM read port between the scan and the head fetch
    assign ram_re    = scan_rd_en || head_re;
    assign ram_raddr = scan_rd_en ? scan_rd_addr : rd_idx_next;

    cfs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_idx),
        .i_wdata (i_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    cfs_scan #(
        .DEPTH (DEPTH)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (scan_start),
        .i_start_addr (r_rd_idx),
        .i_length     (r_occ),
        .i_key        (i_value),
        .i_rdata      (ram_rdata),
        .o_rd_en      (scan_rd_en),
        .o_rd_addr    (scan_rd_addr),
        .o_sts        (scan_sts)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_cmd == CMD_DEQ && r_occ > OCC_W'(1)) begin
                        n_state = ST_HEAD;
                    end else if (i_cmd == CMD_SRCH && r_occ != '0) begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_HEAD: begin
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                if (scan_sts.done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Queue updates, RAM control and result formation
    always_comb begin
        n_rd_idx   = r_rd_idx;
        n_wr_idx   = r_wr_idx;
        n_occ      = r_occ;
        n_head     = r_head;
        n_tail     = r_tail;
        ram_we     = 1'b0;
        head_re    = 1'b0;
        scan_start = 1'b0;
        res_load   = 1'b0;
        res_ok     = 1'b0;
        res_pop    = '0;
        res_found  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        CMD_ENQ: begin
                            res_load = 1'b1;
                            if (!full) begin
                                ram_we   = 1'b1;
                                n_wr_idx = wr_idx_next;
                                n_occ    = r_occ + 1'b1;
                                n_tail   = i_value;
                                res_ok   = 1'b1;
                                if (r_occ == '0) begin
                                    n_head = i_value;
                                end
                            end
                        end
                        CMD_DEQ: begin
                            if (r_occ != '0) begin
                                n_rd_idx = rd_idx_next;
                                n_occ    = r_occ - 1'b1;
                                res_ok   = 1'b1;
                                res_pop  = r_head;
                            end
                            // fetch the new head when words remain
                            if (r_occ > OCC_W'(1)) begin
                                head_re = 1'b1;
                            end else begin
                                res_load = 1'b1;
                            end
                        end
                        CMD_SRCH: begin
                            if (r_occ != '0) begin
                                scan_start = 1'b1;
                            end else begin
                                res_load = 1'b1;
                            end
                        end
                        default: begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_HEAD: begin
                n_head   = ram_rdata;
                res_load = 1'b1;
                res_ok   = 1'b1;
                res_pop  = r_head;
            end
            ST_SCAN: begin
                if (scan_sts.done) begin
                    res_load  = 1'b1;
                    res_found = scan_sts.found;
                end
            end
            default: begin
                res_load = 1'b0;
            end
        endcase
    end

    // Hold queue state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_idx <= '0;
            r_wr_idx <= '0;
            r_occ    <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_idx <= n_rd_idx;
            r_wr_idx <= n_wr_idx;
            r_occ    <= n_occ;
        end
        r_head <= n_head;
        r_tail <= n_tail;
    end

    // Load the result register; drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (res_load) begin
            r_ok       <= res_ok;
            r_pop      <= res_pop;
            r_found    <= res_found;
            r_head_out <= (n_occ != '0) ? n_head : EMPTY_WORD;
            r_tail_out <= (n_occ != '0) ? n_tail : EMPTY_WORD;
            r_occ_out  <= n_occ;
        end
    end

    // Count masked to its field width
    assign count_ext = {{COUNT_W{1'b0}}, r_occ_out};

    assign o_out_valid    = r_out_valid;
    assign o_ok           = r_ok;
    assign o_popped_value = r_pop;
    assign o_found        = r_found;
    assign o_head_value   = r_head_out;
    assign o_tail_value   = r_tail_out;
    assign o_count        = count_ext[COUNT_W-1:0];

endmodule

### rtl/cfs_ram.sv
// ----------------------------------------------------------------------------
// cfs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/cfs_scan.sv
// ----------------------------------------------------------------------------
// cfs_scan
// Search unit: walks the live slots from the head, one RAM read per cycle,
// and compares each returned word against the key with one comparator.
// ----------------------------------------------------------------------------
module cfs_scan #(
    parameter int DEPTH = cfs_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [$clog2(DEPTH)-1:0]     i_start_addr,
    input  logic [$clog2(DEPTH+1)-1:0]   i_length,
    input  logic [cfs_pkg::WORD_W-1:0]   i_key,
    input  logic [cfs_pkg::WORD_W-1:0]   i_rdata,
    output logic                         o_rd_en,
    output logic [$clog2(DEPTH)-1:0]     o_rd_addr,
    output cfs_pkg::t_scan_sts           o_sts
);

    import cfs_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic              r_busy,     n_busy;
    logic [PTR_W-1:0]  r_addr,     n_addr;
    logic [OCC_W-1:0]  r_left,     n_left;
    logic              r_cmp_vld,  n_cmp_vld;
    logic              r_cmp_last, n_cmp_last;
    logic [WORD_W-1:0] r_key,      n_key;
    logic              match;
    logic              done;

    // Compare the word that came back from the RAM
    assign match     = (i_rdata == r_key);
    assign done      = r_cmp_vld && (match || r_cmp_last);
    assign o_rd_en   = r_busy && (r_left != '0);
    assign o_rd_addr = r_addr;
    assign o_sts     = '{done: done, found: r_cmp_vld && match};

    // Issue reads and track the compare pipeline
    always_comb begin
        n_busy     = r_busy;
        n_addr     = r_addr;
        n_left     = r_left;
        n_cmp_vld  = r_cmp_vld;
        n_cmp_last = r_cmp_last;
        n_key      = r_key;
        if (i_start) begin
            n_busy    = 1'b1;
            n_addr    = i_start_addr;
            n_left    = i_length;
            n_cmp_vld = 1'b0;
            n_key     = i_key;
        end else if (done) begin
            n_busy    = 1'b0;
            n_left    = '0;
            n_cmp_vld = 1'b0;
        end else begin
            n_cmp_vld = o_rd_en;
            if (o_rd_en) begin
                n_addr     = (r_addr == PTR_LAST) ? '0 : r_addr + 1'b1;
                n_left     = r_left - 1'b1;
                n_cmp_last = (r_left == OCC_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_busy    <= n_busy;
            r_cmp_vld <= n_cmp_vld;
        end
        r_addr     <= n_addr;
        r_left     <= n_left;
        r_cmp_last <= n_cmp_last;
        r_key      <= n_key;
    end

endmodule

### bench/circular_fifo_with_search_tb.sv
// ----------------------------------------------------------------------------
// circular_fifo_with_search_tb
// Self-checking bench for the ring-buffer FIFO with search.
// ----------------------------------------------------------------------------
// A short table of directed requests runs first: an empty queue, the extreme
// words, searches that hit the head, the tail or nothing, the undefined
// command, and a dequeue that empties the queue. Some rows carry a typed-in
// result. Random episodes follow: fill past full, drain past empty, and mixed
// traffic with searches often aimed at words that were enqueued. Each accepted
// request is run through a local model of the queue. Each result is checked
// field by field against the oldest pending prediction. Both handshakes idle
// in random bursts, except in some random episodes and in the last stretch of the run.
// ----------------------------------------------------------------------------
module circular_fifo_with_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cfs_pkg::*;

    localparam int DEPTH     = DEPTH_DEF;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int N_RANDOM  = 700;
    localparam logic [CMD_W-1:0] CMD_UNDEF = 2'd3;

    typedef struct packed {
        logic               ok;
        logic [WORD_W-1:0]  popped;
        logic               found;
        logic [WORD_W-1:0]  head;
        logic [WORD_W-1:0]  tail;
        logic [COUNT_W-1:0] count;
    } t_fifo_result;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] value;
        logic              typed;
        t_fifo_result      res;
    } t_dir_row;

    // DUT ports
    logic                     i_clk          = 1'b0;
    logic                     i_rst_n        = 1'b0;
    logic                     i_in_valid     = 1'b0;
    logic                     o_in_ready;
    logic [CMD_W-1:0]         i_cmd          = CMD_ENQ;
    logic signed [WORD_W-1:0] i_value        = '0;
    logic                     o_out_valid;
    logic                     i_out_ready    = 1'b0;
    logic                     o_ok;
    logic signed [WORD_W-1:0] o_popped_value;
    logic                     o_found;
    logic signed [WORD_W-1:0] o_head_value;
    logic signed [WORD_W-1:0] o_tail_value;
    logic [COUNT_W-1:0]       o_count;

    // Typed-in result that travels with a directed request
    logic                     typed_use = 1'b0;
    t_fifo_result             typed_res = '0;

    // Queue model
    logic [WORD_W-1:0]        slot_mem [DEPTH];
    logic [PTR_W-1:0]         rd_ptr = '0;
    logic [PTR_W-1:0]         wr_ptr = '0;
    int                       fill_level = 0;

    t_fifo_result             pending_results [$];
    logic [WORD_W-1:0]        recent_words [$];
    t_dir_row                 dir_table [$];

    bit                       idle_en = 1'b1;
    int                       n_errors = 0;
    int                       n_checked = 0;
    int                       n_found = 0;
    int                       n_refused = 0;
    int                       n_sent = 0;

    circular_fifo_with_search #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_ok           (o_ok),
        .o_popped_value (o_popped_value),
        .o_found        (o_found),
        .o_head_value   (o_head_value),
        .o_tail_value   (o_tail_value),
        .o_count        (o_count)
    );

    // Generate the clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Bound the run
    initial begin
        #2_000_000;
        $display("circular_fifo_with_search_tb: done, errors");
        $finish;
    end

    // Apply one request to the queue model and return its result
    function automatic t_fifo_result fifo_apply(input logic [CMD_W-1:0] cmd,
                                                input logic [WORD_W-1:0] word);
        t_fifo_result     r;
        logic [PTR_W-1:0] p;
        r       = '0;
        r.head  = EMPTY_WORD;
        r.tail  = EMPTY_WORD;
        case (cmd)
            CMD_ENQ: begin
                if (fill_level < DEPTH) begin
                    slot_mem[wr_ptr] = word;
                    wr_ptr           = wr_ptr + 1'b1;
                    fill_level++;
                    r.ok             = 1'b1;
                end
            end
            CMD_DEQ: begin
                if (fill_level != 0) begin
                    r.popped = slot_mem[rd_ptr];
                    rd_ptr   = rd_ptr + 1'b1;
                    fill_level--;
                    r.ok     = 1'b1;
                end
            end
            CMD_SRCH: begin
                p = rd_ptr;
                for (int i = 0; i < fill_level; i++) begin
                    if (slot_mem[p] == word) r.found = 1'b1;
                    p = p + 1'b1;
                end
            end
            default: ;
        endcase
        if (fill_level != 0) begin
            r.head = slot_mem[rd_ptr];
            r.tail = slot_mem[wr_ptr - 1'b1];
        end
        r.count = fill_level[COUNT_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got) begin
            n_errors++;
            $display("%0t ns: %s mismatch, expected %h, actual %h",
                     $time, name, want, got);
        end
    endtask

    // Check results and predict accepted requests
    always @(posedge i_clk) begin
        t_fifo_result want;
        t_fifo_result pred;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    n_errors++;
                    $display({"%0t ns: result with no request pending, ",
                              "expected none, actual count %h"},
                             $time, o_count);
                end else begin
                    want = pending_results.pop_front();
                    check_field("ok", {31'b0, want.ok}, {31'b0, o_ok});
                    check_field("popped_value", want.popped, o_popped_value);
                    check_field("found", {31'b0, want.found}, {31'b0, o_found});
                    check_field("head_value", want.head, o_head_value);
                    check_field("tail_value", want.tail, o_tail_value);
                    check_field("count", {25'b0, want.count}, {25'b0, o_count});
                    n_checked++;
                    if (want.found) n_found++;
                    if (!want.ok && (want.popped == '0) && !want.found) n_refused++;
                end
            end
            if (i_in_valid && o_in_ready) begin
                pred = fifo_apply(i_cmd, i_value);
                pending_results.push_back(typed_use ? typed_res : pred);
            end
        end
    end

    // Drive the result side: ready with random stall bursts
    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (idle_en && ($urandom_range(0, 3) == 0)) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
    end

    // Present one request and hold it until accepted
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] word,
                                input logic typed, input t_fifo_result res);
        if (idle_en && ($urandom_range(0, 4) == 0)) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_value    <= word;
        typed_use  <= typed;
        typed_res  <= res;
        do @(posedge i_clk); while (!o_in_ready);
        n_sent++;
        if (cmd == CMD_ENQ) begin
            recent_words.push_back(word);
            if (recent_words.size() > DEPTH) void'(recent_words.pop_front());
        end
    endtask

    task automatic send_plain(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] word);
        send_request(cmd, word, 1'b0, '0);
    endtask

    // Hold the sender until every pending result has come back
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) return $urandom;
        if (sel < 55) begin
            case ($urandom_range(0, 4))
                0:       return 32'h0000_0000;
                1:       return 32'hFFFF_FFFF;
                2:       return 32'h7FFF_FFFF;
                3:       return 32'h8000_0000;
                default: return 32'h0000_0001;
            endcase
        end
        return 32'($urandom_range(0, 15));
    endfunction

    function automatic logic [WORD_W-1:0] pick_key();
        if ((recent_words.size() != 0) && ($urandom_range(0, 1) == 0))
            return recent_words[$urandom_range(0, recent_words.size() - 1)];
        return pick_word();
    endfunction

    function automatic void add_row(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] word,
                                    input logic typed, input logic ok,
                                    input logic [WORD_W-1:0] popped, input logic found,
                                    input logic [WORD_W-1:0] head,
                                    input logic [WORD_W-1:0] tail,
                                    input logic [COUNT_W-1:0] count);
        t_dir_row row;
        row.cmd   = cmd;
        row.value = word;
        row.typed = typed;
        row.res   = '{ok, popped, found, head, tail, count};
        dir_table.push_back(row);
    endfunction

    task automatic run_fill();
        int extra;
        extra = $urandom_range(1, 3);
        repeat (DEPTH + extra) send_plain(CMD_ENQ, pick_word());
        send_plain(CMD_SRCH, recent_words[recent_words.size() - 1]);
        send_plain(CMD_SRCH, pick_key());
        send_plain(CMD_SRCH, $urandom);
        send_plain(CMD_ENQ, pick_word());
    endtask

    task automatic run_drain();
        int extra;
        extra = $urandom_range(1, 3);
        repeat (DEPTH + extra) send_plain(CMD_DEQ, $urandom);
        send_plain(CMD_SRCH, pick_key());
    endtask

    task automatic run_mixed();
        int len;
        int enq_w;
        int sel;
        len   = $urandom_range(20, 60);
        enq_w = 30 + 15 * $urandom_range(0, 2);
        repeat (len) begin
            sel = $urandom_range(0, 99);
            if (sel < enq_w)          send_plain(CMD_ENQ, pick_word());
            else if (sel < enq_w + 30) send_plain(CMD_DEQ, $urandom);
            else if (sel < 96)        send_plain(CMD_SRCH, pick_key());
            else                      send_plain(CMD_UNDEF, $urandom);
        end
    endtask

    initial begin
        int n_dir;
        int kind;
        for (int i = 0; i < DEPTH; i++) slot_mem[i] = '0;

        // Empty queue, then extremes, then back to empty
        add_row(CMD_DEQ,   32'h0000_0000, 1, 0, 0, 0, EMPTY_WORD, EMPTY_WORD, 0);
        add_row(CMD_SRCH,  32'h0000_0000, 1, 0, 0, 0, EMPTY_WORD, EMPTY_WORD, 0);
        add_row(CMD_SRCH,  32'hFFFF_FFFF, 1, 0, 0, 0, EMPTY_WORD, EMPTY_WORD, 0);
        add_row(CMD_UNDEF, 32'h1234_5678, 1, 0, 0, 0, EMPTY_WORD, EMPTY_WORD, 0);
        add_row(CMD_ENQ,   32'h7FFF_FFFF, 1, 1, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
        add_row(CMD_ENQ,   32'h8000_0000, 1, 1, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 2);
        add_row(CMD_SRCH,  32'h8000_0000, 1, 0, 0, 1, 32'h7FFF_FFFF, 32'h8000_0000, 2);
        add_row(CMD_SRCH,  32'h7FFF_FFFF, 1, 0, 0, 1, 32'h7FFF_FFFF, 32'h8000_0000, 2);
        add_row(CMD_SRCH,  32'h0000_0000, 1, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 2);
        add_row(CMD_UNDEF, 32'h8000_0000, 1, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 2);
        add_row(CMD_ENQ,   32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
        add_row(CMD_ENQ,   32'h0000_0000, 0, 0, 0, 0, 0, 0, 0);
        add_row(CMD_SRCH,  32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
        add_row(CMD_DEQ,   32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
        add_row(CMD_DEQ,   32'h0000_0000, 0, 0, 0, 0, 0, 0, 0);
        add_row(CMD_ENQ,   32'h0000_0001, 0, 0, 0, 0, 0, 0, 0);
        add_row(CMD_SRCH,  32'h0000_0000, 0, 0, 0, 0, 0, 0, 0);
        add_row(CMD_SRCH,  32'h0000_0001, 0, 0, 0, 0, 0, 0, 0);
        add_row(CMD_DEQ,   32'h0000_0000, 0, 0, 0, 0, 0, 0, 0);
        add_row(CMD_DEQ,   32'h0000_0000, 0, 0, 0, 0, 0, 0, 0);
        add_row(CMD_DEQ,   32'h0000_0000, 0, 0, 0, 0, 0, 0, 0);
        add_row(CMD_DEQ,   32'h0000_0000, 0, 0, 0, 0, 0, 0, 0);
        add_row(CMD_ENQ,   32'h5A5A_A5A5, 0, 0, 0, 0, 0, 0, 0);
        add_row(CMD_DEQ,   32'h0000_0000, 0, 0, 0, 0, 0, 0, 0);

        // Hold reset, then release it
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (dir_table[i])
            send_request(dir_table[i].cmd, dir_table[i].value, dir_table[i].typed,
                         dir_table[i].res);
        n_dir = n_sent;
        wait_quiet();

        // Random episodes: first fill and drain, then a mix
        run_fill();
        run_drain();
        while (n_sent < n_dir + N_RANDOM) begin
            if (n_sent >= n_dir + N_RANDOM - 120) idle_en = 1'b0;
            else                                 idle_en = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 9);
            if (kind < 2)       run_fill();
            else if (kind < 4)  run_drain();
            else                run_mixed();
            if ((kind == 9) && idle_en) wait_quiet();
        end

        // Let the last results come back
        wait_quiet();
        repeat (80) @(posedge i_clk);

        $display("Checked %0d results from %0d requests: %0d searches hit, %0d refused or no-op.",
                 n_checked, n_sent, n_found, n_refused);
        $display("Covered empty and full queues, pointer wrap, extreme words and undefined commands.");
        if (n_errors == 0) begin
            $display("circular_fifo_with_search_tb: done, clean");
        end else begin
            $display("circular_fifo_with_search_tb: done, errors");
        end
        $finish;
    end

endmodule
